// ===== rtl/memory_range_slot_manager_core_defines.svh =====
// ----------------------------------------------------------------------------
// memory range slot manager assertion macros
// Checks that are switched off together when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MEMORY_RANGE_SLOT_MANAGER_CORE_DEFINES_SVH
`define MEMORY_RANGE_SLOT_MANAGER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication under reset
`define MRSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mrsm: implication check failed");
// next-cycle implication under reset
`define MRSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mrsm: next-cycle check failed");
`else
`define MRSM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MRSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/mrsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mrsm_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package mrsm_pkg;

    localparam int NUM_SLOTS = 2;
    localparam int SLOT_W    = 1;
    localparam int ACT_W     = 2;
    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 33;
    localparam int ADDR_LSB  = 17;
    localparam int BASE_W    = ADDR_W - ADDR_LSB;
    localparam int MASK_W    = 15;
    localparam int HALF_W    = 32;
    localparam int IMG_W     = HALF_W * NUM_SLOTS;
    localparam int STAT_W    = 3;

    localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(131072);

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 3'd0,
        ST_INVALID     = 3'd1,
        ST_UNSUPPORTED = 3'd2,
        ST_EXISTS      = 3'd3,
        ST_NOSPACE     = 3'd4,
        ST_NOTFOUND    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [ACT_W-1:0]     action;
        logic                 fmt_ok;
        logic                 other;
        logic [NUM_SLOTS-1:0] empty;
        logic [NUM_SLOTS-1:0] match;
    } t_dp_sts;

    typedef struct packed {
        logic              load;
        logic              exec;
        logic              wr_add;
        logic              wr_clear;
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_dp_cmd;

endpackage

// ===== rtl/memory_range_slot_manager_core.sv =====
// sequencing: an accepted request is executed in the execute state, and its result
//   is then held in the result state until it is taken
// flow: a new request is accepted while idle, or in the cycle the result is
//   taken, so the execute and result states keep requests from overlapping
// reset: synchronous active low; all slots empty and the register image zero
// ----------------------------------------------------------------------------
// memory_range_slot_manager_core
// Two-slot memory-range attribute table with its 64-bit register image.
// ----------------------------------------------------------------------------
`include "memory_range_slot_manager_core_defines.svh"

module memory_range_slot_manager_core import mrsm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  logic [ACT_W-1:0]     i_action,
    input  logic [ADDR_W-1:0]    i_base,
    input  logic [LEN_W-1:0]     i_length,
    input  logic                 i_write_combine,
    input  logic                 i_uncacheable,
    input  logic                 i_force_req,
    input  logic                 i_other_flags,
    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output logic [STAT_W-1:0]    o_status,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [IMG_W-1:0]     o_register_image
);

    t_dp_sts sts;
    t_dp_cmd cmd;
    logic    req_acc;
    logic    rsp_fail;
    logic    rsp_held;

    // force flag has no effect on the register image
    logic    force_unused;
    assign force_unused = i_force_req;

    assign req_acc  = i_req_valid && o_req_ready;
    assign rsp_fail = o_rsp_valid && (o_status != ST_OK);
    assign rsp_held = o_rsp_valid && !i_rsp_ready;

    mrsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mrsm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_action         (i_action),
        .i_base           (i_base),
        .i_length         (i_length),
        .i_write_combine  (i_write_combine),
        .i_uncacheable    (i_uncacheable),
        .i_other_flags    (i_other_flags),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_register_image (o_register_image)
    );

    `MRSM_ASSERT_NEXT(a_no_rsp_after_req, i_clk, i_rst_n, req_acc, !o_rsp_valid)
    `MRSM_ASSERT_NEXT(a_rsp_two_after_req, i_clk, i_rst_n, req_acc, ##1 o_rsp_valid)
    `MRSM_ASSERT_IMPL(a_slot_zero_on_fail, i_clk, i_rst_n, rsp_fail, o_slot == '0)
    `MRSM_ASSERT_NEXT(a_image_stable_out, i_clk, i_rst_n, rsp_held, $stable(o_register_image))
    `MRSM_ASSERT_NEXT(a_status_stable_out, i_clk, i_rst_n, rsp_held, $stable(o_status))

endmodule

// ===== rtl/mrsm_dp.sv =====
// ----------------------------------------------------------------------------
// mrsm_dp
// Request capture, slot table, range checks, word encoding and register image.
// ----------------------------------------------------------------------------
module mrsm_dp import mrsm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [ACT_W-1:0]     i_action,
    input  logic [ADDR_W-1:0]    i_base,
    input  logic [LEN_W-1:0]     i_length,
    input  logic                 i_write_combine,
    input  logic                 i_uncacheable,
    input  logic                 i_other_flags,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic [STAT_W-1:0]    o_status,
    output logic [SLOT_W-1:0]    o_slot,
    output logic [IMG_W-1:0]     o_register_image
);

    logic [ACT_W-1:0]  r_act;
    logic [ADDR_W-1:0] r_base;
    logic [LEN_W-1:0]  r_len;
    logic              r_wc;
    logic              r_uc;
    logic              r_oth;

    logic [BASE_W-1:0] r_slot_base [NUM_SLOTS];
    logic [LEN_W-1:0]  r_slot_len  [NUM_SLOTS];
    logic [IMG_W-1:0]  r_attr;
    logic [IMG_W-1:0]  n_attr;
    logic [STAT_W-1:0] r_status;
    logic [SLOT_W-1:0] r_slot;

    logic [LEN_W-1:0]  len_dec;
    logic [MASK_W-1:0] mask;
    logic              mask_acc;
    logic [HALF_W-1:0] word;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_action;
            r_base <= i_base;
            r_len  <= i_length;
            r_wc   <= i_write_combine;
            r_uc   <= i_uncacheable;
            r_oth  <= i_other_flags;
        end
    end

    assign len_dec = r_len - LEN_W'(1);

    // len is a power of two here, so a prefix or over its upper bits gives the mask
    always_comb begin
        mask_acc = 1'b0;
        for (int j = 0; j < MASK_W; j++) begin
            mask_acc = mask_acc | r_len[ADDR_LSB + j];
            mask[j]  = mask_acc;
        end
    end

    assign word = {r_base[ADDR_W-1:ADDR_LSB], mask, r_wc, r_uc};

    always_comb begin
        o_sts.action = r_act;
        o_sts.fmt_ok = (r_base[ADDR_LSB-1:0] == '0) && (r_len >= MIN_LEN)
                       && ((r_len & len_dec) == '0);
        o_sts.other  = r_oth;
        for (int d = 0; d < NUM_SLOTS; d++) begin
            o_sts.empty[d] = (r_slot_len[d] == '0);
            o_sts.match[d] = (r_slot_len[d] != '0)
                             && ({r_slot_base[d], ADDR_LSB'(0)} == r_base)
                             && (r_slot_len[d] == r_len);
        end
    end

    always_comb begin
        n_attr = r_attr;
        for (int d = 0; d < NUM_SLOTS; d++) begin
            if (i_cmd.exec && i_cmd.slot == SLOT_W'(d)) begin
                if (i_cmd.wr_add) begin
                    n_attr[HALF_W*d +: HALF_W] = word;
                end else if (i_cmd.wr_clear) begin
                    n_attr[HALF_W*d +: HALF_W] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < NUM_SLOTS; d++) begin
                r_slot_base[d] <= '0;
                r_slot_len[d]  <= '0;
            end
            r_attr <= '0;
        end else begin
            r_attr <= n_attr;
            for (int d = 0; d < NUM_SLOTS; d++) begin
                if (i_cmd.exec && i_cmd.slot == SLOT_W'(d)) begin
                    if (i_cmd.wr_add) begin
                        r_slot_base[d] <= r_base[ADDR_W-1:ADDR_LSB];
                        r_slot_len[d]  <= r_len;
                    end else if (i_cmd.wr_clear) begin
                        r_slot_base[d] <= '0;
                        r_slot_len[d]  <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= i_cmd.status;
            r_slot   <= i_cmd.slot;
        end
    end

    assign o_status         = r_status;
    assign o_slot           = r_slot;
    assign o_register_image = r_attr;

endmodule

// ===== rtl/mrsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrsm_ctrl
// Request sequencing and slot decision: picks the result code and slot.
// ----------------------------------------------------------------------------
module mrsm_ctrl import mrsm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    output logic    o_rsp_valid,
    input  logic    i_rsp_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state            r_state;
    t_state            n_state;
    t_status           res_status;
    logic [SLOT_W-1:0] res_slot;
    logic              res_add;
    logic              res_clear;
    logic              found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // in-order slot scan, first hit wins
    always_comb begin
        res_status = ST_UNSUPPORTED;
        res_slot   = '0;
        res_add    = 1'b0;
        res_clear  = 1'b0;
        found      = 1'b0;
        case (t_action'(i_sts.action))
            ACT_ADD: begin
                if (!i_sts.fmt_ok) begin
                    res_status = ST_INVALID;
                end else if (i_sts.other) begin
                    res_status = ST_UNSUPPORTED;
                end else begin
                    res_status = ST_NOSPACE;
                    for (int d = 0; d < NUM_SLOTS; d++) begin
                        if (!found) begin
                            if (i_sts.empty[d]) begin
                                found      = 1'b1;
                                res_status = ST_OK;
                                res_slot   = SLOT_W'(d);
                                res_add    = 1'b1;
                            end else if (i_sts.match[d]) begin
                                found      = 1'b1;
                                res_status = ST_EXISTS;
                            end
                        end
                    end
                end
            end
            ACT_REMOVE: begin
                res_status = ST_NOTFOUND;
                for (int d = 0; d < NUM_SLOTS; d++) begin
                    if (!found && i_sts.match[d]) begin
                        found      = 1'b1;
                        res_status = ST_OK;
                        res_slot   = SLOT_W'(d);
                        res_clear  = 1'b1;
                    end
                end
            end
            default: begin
                res_status = ST_UNSUPPORTED;
            end
        endcase
    end

    always_comb begin
        n_state        = r_state;
        o_req_ready    = 1'b0;
        o_rsp_valid    = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.wr_add   = 1'b0;
        o_cmd.wr_clear = 1'b0;
        o_cmd.slot     = res_slot;
        o_cmd.status   = res_status;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec     = 1'b1;
                o_cmd.wr_add   = res_add;
                o_cmd.wr_clear = res_clear;
                n_state        = S_OUT;
            end
            S_OUT: begin
                o_rsp_valid = 1'b1;
                o_req_ready = i_rsp_ready;
                if (i_rsp_ready) begin
                    if (i_req_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_EXEC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/memory_range_slot_manager_core_tb.sv =====
// ----------------------------------------------------------------------------
// memory_range_slot_manager_core_tb
// Drives add, remove and other requests into the two-slot range table with
// random gaps and back-pressure, and checks the status, slot and register
// image of every response against a predictor of the table kept here.
// ----------------------------------------------------------------------------
module memory_range_slot_manager_core_tb;
    import mrsm_pkg::*;

    localparam logic [ACT_W-1:0] ACT_OTHER_A = 2'd2;
    localparam logic [ACT_W-1:0] ACT_OTHER_B = 2'd3;
    localparam int RANDOM_REQS    = 550;
    localparam int CALM_TAIL      = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_SIZE      = 6;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  length;
        logic              wc;
        logic              uc;
        logic              frc;
        logic              oth;
        logic              wait_drain;
    } range_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [IMG_W-1:0]  image;
    } range_rsp_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_req_valid = 1'b0;
    logic                 o_req_ready;
    logic [ACT_W-1:0]     i_action = '0;
    logic [ADDR_W-1:0]    i_base = '0;
    logic [LEN_W-1:0]     i_length = '0;
    logic                 i_write_combine = 1'b0;
    logic                 i_uncacheable = 1'b0;
    logic                 i_force_req = 1'b0;
    logic                 i_other_flags = 1'b0;
    logic                 o_rsp_valid;
    logic                 i_rsp_ready = 1'b0;
    logic [STAT_W-1:0]    o_status;
    logic [SLOT_W-1:0]    o_slot;
    logic [IMG_W-1:0]     o_register_image;

    // predictor copy of the table
    logic [BASE_W-1:0] tbl_base  [NUM_SLOTS];
    logic [LEN_W-1:0]  tbl_len   [NUM_SLOTS];
    logic [2:0]        tbl_flags [NUM_SLOTS];
    logic [IMG_W-1:0]  attr_image;

    range_req_t request_q[$];
    range_rsp_t predicted_rsp_q[$];
    range_req_t cur_req;

    int  sent_count = 0;
    int  rsp_count = 0;
    int  error_count = 0;
    int  calm_from = 1 << 30;
    bit  calm = 1'b0;
    int  send_gap = 0;
    int  send_idle_pct = 20;
    int  rsp_stall = 0;
    int  recv_idle_pct = 20;
    int  idle_cycles = 0;
    int  status_hits [8];

    memory_range_slot_manager_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_req_valid),
        .o_req_ready      (o_req_ready),
        .i_action         (i_action),
        .i_base           (i_base),
        .i_length         (i_length),
        .i_write_combine  (i_write_combine),
        .i_uncacheable    (i_uncacheable),
        .i_force_req      (i_force_req),
        .i_other_flags    (i_other_flags),
        .o_rsp_valid      (o_rsp_valid),
        .i_rsp_ready      (i_rsp_ready),
        .o_status         (o_status),
        .o_slot           (o_slot),
        .o_register_image (o_register_image)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [MASK_W-1:0] range_mask(logic [LEN_W-1:0] len);
        int lg;
        lg = 0;
        for (int b = 0; b < LEN_W; b++) begin
            if (len[b]) begin
                lg = b;
            end
        end
        if (lg < ADDR_LSB || lg - ADDR_LSB >= MASK_W) begin
            return '0;
        end
        return MASK_W'(15'h7fff << (lg - ADDR_LSB));
    endfunction

    function automatic range_rsp_t predict_range_op(range_req_t rq);
        range_rsp_t rs;
        logic       done;
        rs.status = ST_OK;
        rs.slot   = '0;
        done      = 1'b0;
        case (rq.action)
            ACT_ADD: begin
                if (rq.base[ADDR_LSB-1:0] != '0 || rq.length < MIN_LEN ||
                    (rq.length & (rq.length - 1'b1)) != '0) begin
                    rs.status = ST_INVALID;
                end else if (rq.oth) begin
                    rs.status = ST_UNSUPPORTED;
                end else begin
                    rs.status = ST_NOSPACE;
                    for (int d = 0; d < NUM_SLOTS; d++) begin
                        if (!done) begin
                            // first empty slot wins, unless a duplicate sits ahead of it
                            if (tbl_len[d] == '0) begin
                                tbl_base[d]  = rq.base[ADDR_W-1:ADDR_LSB];
                                tbl_len[d]   = rq.length;
                                tbl_flags[d] = {rq.frc, rq.uc, rq.wc};
                                attr_image[HALF_W*d +: HALF_W] =
                                    {rq.base[ADDR_W-1:ADDR_LSB], range_mask(rq.length),
                                     rq.wc, rq.uc};
                                rs.status = ST_OK;
                                rs.slot   = SLOT_W'(d);
                                done      = 1'b1;
                            end else if ({tbl_base[d], {ADDR_LSB{1'b0}}} == rq.base &&
                                         tbl_len[d] == rq.length) begin
                                rs.status = ST_EXISTS;
                                done      = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_REMOVE: begin
                rs.status = ST_NOTFOUND;
                for (int d = 0; d < NUM_SLOTS; d++) begin
                    if (!done && tbl_len[d] != '0 &&
                        {tbl_base[d], {ADDR_LSB{1'b0}}} == rq.base &&
                        tbl_len[d] == rq.length) begin
                        tbl_base[d]  = '0;
                        tbl_len[d]   = '0;
                        tbl_flags[d] = '0;
                        attr_image[HALF_W*d +: HALF_W] = '0;
                        rs.status = ST_OK;
                        rs.slot   = SLOT_W'(d);
                        done      = 1'b1;
                    end
                end
            end
            default: begin
                rs.status = ST_UNSUPPORTED;
            end
        endcase
        rs.image = attr_image;
        return rs;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 20;
            default: return 50;
        endcase
    endfunction

    // request driver
    always @(posedge i_clk) begin
        logic launch;
        launch = 1'b0;
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else begin
            if (i_req_valid && o_req_ready) begin
                predicted_rsp_q.push_back(predict_range_op(cur_req));
                sent_count++;
                if (sent_count % 64 == 0) begin
                    send_idle_pct = pick_idle_pct();
                end
            end
            calm = (sent_count >= calm_from);
            if (!(i_req_valid && !o_req_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_q.size() != 0 &&
                             !(request_q[0].wait_drain && predicted_rsp_q.size() != 0)) begin
                    cur_req = request_q.pop_front();
                    launch  = 1'b1;
                    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
                        send_gap = $urandom_range(1, 12);
                    end
                end
                i_req_valid <= launch;
                if (launch) begin
                    i_action        <= cur_req.action;
                    i_base          <= cur_req.base;
                    i_length        <= cur_req.length;
                    i_write_combine <= cur_req.wc;
                    i_uncacheable   <= cur_req.uc;
                    i_force_req     <= cur_req.frc;
                    i_other_flags   <= cur_req.oth;
                end
            end
        end
    end

    // response monitor and back-pressure
    always @(posedge i_clk) begin
        range_rsp_t want;
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else begin
            if (o_rsp_valid && i_rsp_ready) begin
                rsp_count++;
                if (rsp_count % 64 == 0) begin
                    recv_idle_pct = pick_idle_pct();
                end
                if (predicted_rsp_q.size() == 0) begin
                    $error("response with no request outstanding: status %0d", o_status);
                    error_count++;
                end else begin
                    want = predicted_rsp_q.pop_front();
                    status_hits[want.status]++;
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, o_slot);
                        error_count++;
                    end
                    if (o_register_image !== want.image) begin
                        $error("register_image: expected %h, got %h",
                               want.image, o_register_image);
                        error_count++;
                    end
                end
            end
            if (rsp_stall > 0) begin
                rsp_stall--;
                i_rsp_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
                rsp_stall = $urandom_range(0, 11);
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                         idle_cycles, predicted_rsp_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic push_req(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] base,
                            input logic [LEN_W-1:0] len, input logic wc, input logic uc,
                            input logic frc, input logic oth, input logic drain);
        range_req_t rq;
        rq.action     = act;
        rq.base       = base;
        rq.length     = len;
        rq.wc         = wc;
        rq.uc         = uc;
        rq.frc        = frc;
        rq.oth        = oth;
        rq.wait_drain = drain;
        request_q.push_back(rq);
    endtask

    initial begin
        logic [ADDR_W-1:0] pool_base [POOL_SIZE];
        logic [LEN_W-1:0]  pool_len  [POOL_SIZE];
        logic [ADDR_W-1:0] rb;
        logic [LEN_W-1:0]  rl;
        logic [ACT_W-1:0]  ra;
        logic              roth;
        int                pick;
        int                pi;
        int                total;

        for (int d = 0; d < NUM_SLOTS; d++) begin
            tbl_base[d]  = '0;
            tbl_len[d]   = '0;
            tbl_flags[d] = '0;
        end
        attr_image = '0;

        // directed: every status, the mask extremes and scan order
        push_req(ACT_ADD,    32'h0000_0000, 33'h0_0002_0000, 1, 0, 0, 0, 0);
        push_req(ACT_ADD,    32'h0000_0000, 33'h0_0002_0000, 0, 1, 0, 0, 0);
        push_req(ACT_ADD,    32'hfffe_0000, 33'h1_0000_0000, 0, 1, 1, 0, 0);
        push_req(ACT_ADD,    32'h0002_0000, 33'h0_8000_0000, 1, 1, 1, 0, 0);
        push_req(ACT_ADD,    32'h0001_0000, 33'h0_0002_0000, 0, 0, 0, 0, 0);
        push_req(ACT_ADD,    32'h0004_0000, 33'h0_0000_0000, 0, 0, 0, 0, 0);
        push_req(ACT_ADD,    32'h0004_0000, 33'h0_0001_0000, 0, 0, 0, 0, 0);
        push_req(ACT_ADD,    32'h0004_0000, 33'h0_0006_0000, 0, 0, 0, 0, 0);
        push_req(ACT_ADD,    32'h0004_0000, 33'h1_ffff_ffff, 1, 1, 1, 1, 0);
        push_req(ACT_ADD,    32'h0004_0000, 33'h0_0004_0000, 0, 0, 0, 1, 0);
        push_req(ACT_ADD,    32'h0000_0001, 33'h0_0004_0000, 0, 0, 0, 1, 0);
        push_req(ACT_OTHER_A, 32'hffff_ffff, 33'h1_ffff_ffff, 1, 1, 1, 1, 0);
        push_req(ACT_OTHER_B, 32'h0000_0000, 33'h0_0002_0000, 0, 0, 0, 0, 0);
        push_req(ACT_REMOVE, 32'h0000_0000, 33'h0_0002_0000, 0, 0, 0, 0, 1);
        push_req(ACT_REMOVE, 32'h0000_0000, 33'h0_0002_0000, 0, 0, 0, 0, 0);
        push_req(ACT_REMOVE, 32'h0000_0000, 33'h0_0000_0000, 0, 0, 0, 0, 0);
        push_req(ACT_REMOVE, 32'hfffe_0001, 33'h1_0000_0000, 0, 0, 0, 0, 0);
        push_req(ACT_REMOVE, 32'hfffe_0000, 33'h1_0000_0000, 1, 1, 1, 1, 0);
        push_req(ACT_ADD,    32'h1234_0000, 33'h0_0010_0000, 1, 1, 0, 0, 0);
        push_req(ACT_ADD,    32'h5556_0000, 33'h0_4000_0000, 0, 0, 1, 0, 0);
        push_req(ACT_REMOVE, 32'h1234_0000, 33'h0_0010_0000, 0, 0, 0, 0, 0);
        // slot 0 empty again: a duplicate of slot 1 still lands in slot 0
        push_req(ACT_ADD,    32'h5556_0000, 33'h0_4000_0000, 1, 0, 0, 0, 0);
        push_req(ACT_ADD,    32'h5556_0000, 33'h0_4000_0000, 0, 1, 0, 0, 0);
        push_req(ACT_REMOVE, 32'h5556_0000, 33'h0_4000_0000, 0, 0, 0, 0, 0);
        push_req(ACT_REMOVE, 32'h5556_0000, 33'h0_4000_0000, 0, 0, 0, 0, 0);

        for (int p = 0; p < POOL_SIZE; p++) begin
            rb = $urandom();
            pool_base[p] = {rb[ADDR_W-1:ADDR_LSB], {ADDR_LSB{1'b0}}};
            pool_len[p]  = LEN_W'(1) << $urandom_range(17, 32);
        end

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 100 == 99) begin
                pi = $urandom_range(0, POOL_SIZE - 1);
                rb = $urandom();
                pool_base[pi] = {rb[ADDR_W-1:ADDR_LSB], {ADDR_LSB{1'b0}}};
                pool_len[pi]  = LEN_W'(1) << $urandom_range(17, 32);
            end
            pi   = $urandom_range(0, POOL_SIZE - 1);
            pick = $urandom_range(0, 99);
            roth = 1'b0;
            if (pick < 45) begin
                ra = ACT_ADD;
                rb = pool_base[pi];
                rl = pool_len[pi];
                if ($urandom_range(0, 6) == 0) begin
                    rb = $urandom();
                    rb[ADDR_LSB-1:0] = '0;
                end
                roth = ($urandom_range(0, 9) == 0);
            end else if (pick < 75) begin
                ra = ACT_REMOVE;
                rb = pool_base[pi];
                rl = (($urandom_range(0, 9) == 0) ? pool_len[$urandom_range(0, POOL_SIZE - 1)]
                                                   : pool_len[pi]);
            end else if (pick < 85) begin
                // malformed add: stray low base bits or a bad length
                ra = ACT_ADD;
                rb = pool_base[pi];
                rl = pool_len[pi];
                if ($urandom_range(0, 1) == 0) begin
                    rb[ADDR_LSB-1:0] = ADDR_LSB'($urandom_range(1, (1 << ADDR_LSB) - 1));
                end else begin
                    rl = {$urandom_range(0, 1) == 1, 32'($urandom())};
                end
                roth = 1'($urandom_range(0, 1));
            end else if (pick < 92) begin
                ra = ACT_REMOVE;
                rb = $urandom();
                rl = {$urandom_range(0, 1) == 1, 32'($urandom())};
            end else begin
                ra = ACT_W'($urandom_range(0, 3));
                rb = $urandom();
                rl = {$urandom_range(0, 1) == 1, 32'($urandom())};
                roth = 1'($urandom_range(0, 1));
            end
            push_req(ra, rb, rl, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), roth, n == RANDOM_REQS / 2);
        end

        total     = request_q.size();
        calm_from = total - CALM_TAIL;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || i_req_valid) @(posedge i_clk);
        while (predicted_rsp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d requests driven, %0d responses checked, %0d mismatches",
                 sent_count, rsp_count, error_count);
        $display("status mix: ok %0d invalid %0d unsupported %0d exists %0d full %0d miss %0d",
                 status_hits[ST_OK], status_hits[ST_INVALID], status_hits[ST_UNSUPPORTED],
                 status_hits[ST_EXISTS], status_hits[ST_NOSPACE], status_hits[ST_NOTFOUND]);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
